### sv/fsse_pkg.sv
// Shared constants for the centered same-size FIR filter.
// Register map codes, fixed field widths and bus widths; no dependencies.
`default_nettype none

package fsse_pkg;

  // Coefficient registers and fixed field widths
  localparam int NCOEF       = 5;
  localparam int COEFF_W     = 16;
  localparam int OUT_W       = 35;
  localparam int OUT_TDATA_W = 40;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_IW = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IW-1:0] REG_COEFF_0   = 3'd0;
  localparam logic [REG_IW-1:0] REG_COEFF_1   = 3'd1;
  localparam logic [REG_IW-1:0] REG_COEFF_2   = 3'd2;
  localparam logic [REG_IW-1:0] REG_COEFF_3   = 3'd3;
  localparam logic [REG_IW-1:0] REG_COEFF_4   = 3'd4;
  localparam logic [REG_IW-1:0] REG_EDGE_MODE = 3'd5;

  // Reset value of the center coefficient: 1.0 in Q1.14
  localparam logic signed [COEFF_W-1:0] COEFF_UNITY = 16'sd16384;

endpackage

`default_nettype wire

### sv/fir_same_size_edge_modes.sv
// Top level of the centered same-size FIR filter with zero or replicate edges.
// Depends on fsse_pkg for register codes and fixed widths.
`default_nettype none

// Centered FIR filter, same-size output. Each accepted sample word is
// filtered against the previous samples of its stream; result y[i] leaves
// once sample i+TAPS/2 has arrived, so results lag the input by TAPS/2
// samples. The word marked with s_tlast ends the stream: it yields every
// result still owed (TAPS/2 + 1 of them, fewer for a short stream) and the
// last of those carries m_tlast. Outside the stream, samples read as zero,
// or as the first/last sample when edge_replicate is set. Only the first
// five taps have coefficients (coeff_0..coeff_4, Q1.14); further taps count
// as zero. filtered is the exact sum of products, scaled by 2^14, kept to
// its low 35 bits. Rate: one sample word per clock while the stream runs
// and m_tready does not hold the output; a last word holds s_tready low
// while the work register walks the window, one step per emitted or
// skipped result, and the next word is taken on the last step. Results
// pass the work, product and output registers (the sum is combinational);
// a result waits in the output register while the earlier ones stall once
// full. The user must write configuration through the APB-style port
// at byte address 4*index only while the block is idle; not enforced here.
module fir_same_size_edge_modes #(
  parameter int TAPS         = 5,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  // Input stream: tdata = sample [SAMPLE_WIDTH-1:0], zero padded to bytes
  input  wire logic                                      s_tvalid,
  output logic                                           s_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,
  input  wire logic                                      s_tlast,   // final_sample
  // Result stream: tdata = filtered [34:0], zeros [39:35]
  output logic                                           m_tvalid,
  input  wire logic                                      m_tready,
  output logic [fsse_pkg::OUT_TDATA_W-1:0]               m_tdata,
  output logic                                           m_tlast,   // final_result
  // Configuration port
  input  wire logic                                      psel,
  input  wire logic                                      penable,
  input  wire logic                                      pwrite,
  input  wire logic [fsse_pkg::APB_AW-1:0]               paddr,
  input  wire logic [fsse_pkg::APB_DW-1:0]               pwdata,
  output logic [fsse_pkg::APB_DW-1:0]                    prdata,
  output logic                                           pready
);

  import fsse_pkg::*;

  localparam int HALF   = TAPS / 2;
  localparam int WDEPTH = 2 * HALF;
  localparam int WALLOC = (WDEPTH > 0) ? WDEPTH : 1;
  localparam int LINE_N = WDEPTH + 1;
  localparam int NMUL   = (TAPS < NCOEF) ? TAPS : NCOEF;
  localparam int NVW    = (WDEPTH > 0) ? $clog2(WDEPTH + 1) : 1;
  localparam int DCW    = (HALF > 0) ? $clog2(HALF + 1) : 1;
  localparam int PW     = SAMPLE_WIDTH + COEFF_W;
  localparam int ACCW   = (PW + 3 > OUT_W) ? PW + 3 : OUT_W;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0]      coeff_t;
  typedef logic signed [PW-1:0]           prod_t;
  typedef logic signed [ACCW-1:0]         acc_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  coeff_t              coeff [NCOEF];
  logic                edge_replicate;
  logic [REG_IW-1:0]   reg_index;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_AW-1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NCOEF; k++) begin
        coeff[k] <= (k == int'(REG_COEFF_2)) ? COEFF_UNITY : '0;
      end
      edge_replicate <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_COEFF_0:   coeff[int'(REG_COEFF_0)] <= pwdata[COEFF_W-1:0];
        REG_COEFF_1:   coeff[int'(REG_COEFF_1)] <= pwdata[COEFF_W-1:0];
        REG_COEFF_2:   coeff[int'(REG_COEFF_2)] <= pwdata[COEFF_W-1:0];
        REG_COEFF_3:   coeff[int'(REG_COEFF_3)] <= pwdata[COEFF_W-1:0];
        REG_COEFF_4:   coeff[int'(REG_COEFF_4)] <= pwdata[COEFF_W-1:0];
        REG_EDGE_MODE: edge_replicate <= pwdata[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_COEFF_0:   prdata = {{(APB_DW-COEFF_W){1'b0}}, coeff[int'(REG_COEFF_0)]};
      REG_COEFF_1:   prdata = {{(APB_DW-COEFF_W){1'b0}}, coeff[int'(REG_COEFF_1)]};
      REG_COEFF_2:   prdata = {{(APB_DW-COEFF_W){1'b0}}, coeff[int'(REG_COEFF_2)]};
      REG_COEFF_3:   prdata = {{(APB_DW-COEFF_W){1'b0}}, coeff[int'(REG_COEFF_3)]};
      REG_COEFF_4:   prdata = {{(APB_DW-COEFF_W){1'b0}}, coeff[int'(REG_COEFF_4)]};
      REG_EDGE_MODE: prdata = {{(APB_DW-1){1'b0}}, edge_replicate};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------
  logic o_valid, p_valid, w_valid;
  logic o_free, p_free;
  logic w_emit, w_done, w_step;
  logic s_accept;
  logic w_fin;
  logic [DCW-1:0] w_dc;
  logic [NVW-1:0] w_nv;

  assign o_free   = !o_valid || m_tready;
  assign p_free   = !p_valid || o_free;
  // A final word walks dc from HALF to 0; steps beyond the valid window
  // of a short stream are skipped without a result.
  assign w_emit   = !w_fin || (int'(w_dc) <= int'(w_nv));
  assign w_done   = !w_fin || (w_dc == '0);
  assign w_step   = w_valid && (p_free || !w_emit);
  assign s_tready = !w_valid || (w_step && w_done);
  assign s_accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------------
  // Stream state: window of previous samples, most recent first
  // ---------------------------------------------------------------------
  sample_t        win [WALLOC];
  logic [NVW-1:0] nvalid;       // valid entries, always a prefix of win
  logic           have_first;
  sample_t        first_value;

  sample_t        cur;
  sample_t        firstv;
  sample_t        pad_end;
  sample_t        pad_start;
  sample_t        line_load [LINE_N];
  logic           load_w;

  assign cur       = s_tdata[SAMPLE_WIDTH-1:0];
  assign firstv    = have_first ? first_value : cur;
  assign pad_end   = edge_replicate ? cur : '0;
  assign pad_start = edge_replicate ? firstv : '0;
  // A non-final word produces a result only once HALF samples sit in the window
  assign load_w    = s_tlast || (HALF == 0) || (int'(nvalid) >= HALF);

  // Resolved operands for dc = HALF: entry p is the sample p steps back
  always_comb begin
    line_load[0] = cur;
    for (int p = 1; p < LINE_N; p++) begin
      line_load[p] = (p <= int'(nvalid)) ? win[p-1] : pad_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nvalid     <= '0;
      have_first <= 1'b0;
    end else if (s_accept) begin
      if (s_tlast) begin
        // clear the stream for the next one
        nvalid     <= '0;
        have_first <= 1'b0;
      end else begin
        if (nvalid != NVW'(WDEPTH)) begin
          nvalid <= nvalid + 1'b1;
        end
        have_first <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && !s_tlast) begin
      for (int k = WALLOC - 1; k > 0; k--) begin
        win[k] <= win[k-1];
      end
      win[0]      <= cur;
      first_value <= firstv;
    end
  end

  // ---------------------------------------------------------------------
  // Work register: operand line for the result at distance dc
  // ---------------------------------------------------------------------
  sample_t line [LINE_N];
  sample_t w_pad;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (s_accept && load_w) begin
      w_valid <= 1'b1;
    end else if (w_step && w_done) begin
      w_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && load_w) begin
      for (int p = 0; p < LINE_N; p++) begin
        line[p] <= line_load[p];
      end
      w_fin <= s_tlast;
      w_dc  <= DCW'(HALF);
      w_nv  <= nvalid;
      w_pad <= pad_end;
    end else if (w_step && !w_done) begin
      // advance the center one sample toward the end of the stream
      for (int p = LINE_N - 1; p > 0; p--) begin
        line[p] <= line[p-1];
      end
      line[0] <= w_pad;
      w_dc    <= w_dc - 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Product register: one multiplier per coefficient tap
  // ---------------------------------------------------------------------
  prod_t p_prod [NMUL];
  logic  p_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= w_step && w_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (w_step && w_emit) begin
      for (int j = 0; j < NMUL; j++) begin
        p_prod[j] <= PW'(line[WDEPTH-j]) * PW'(coeff[j]);
      end
      p_last <= w_fin && (w_dc == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Sum and output register
  // ---------------------------------------------------------------------
  acc_t            acc;
  logic [OUT_W-1:0] o_filtered;
  logic            o_last;

  always_comb begin
    acc = '0;
    for (int j = 0; j < NMUL; j++) begin
      acc = acc + ACCW'(p_prod[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && p_valid) begin
      o_filtered <= acc[OUT_W-1:0];  // keep the low bits of the exact sum
      o_last     <= p_last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, o_filtered};
  assign m_tlast  = o_last;

endmodule

`default_nettype wire
